/* hdl/wavhp_pkg.sv */
package wavhp_pkg;

   localparam int unsigned HDR_LEN   = 44;
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned OFF_W     = 6;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   localparam logic [OFF_W-1:0] OFF_RIFF     = 6'd3;
   localparam logic [OFF_W-1:0] OFF_WAVE     = 6'd11;
   localparam logic [OFF_W-1:0] OFF_FMT      = 6'd15;
   localparam logic [OFF_W-1:0] OFF_FMT_SIZE = 6'd19;
   localparam logic [OFF_W-1:0] OFF_FORMAT   = 6'd21;
   localparam logic [OFF_W-1:0] OFF_CHANNELS = 6'd23;
   localparam logic [OFF_W-1:0] OFF_RATE     = 6'd27;
   localparam logic [OFF_W-1:0] OFF_BYTERATE = 6'd31;
   localparam logic [OFF_W-1:0] OFF_ALIGN    = 6'd33;
   localparam logic [OFF_W-1:0] OFF_BITS     = 6'd35;
   localparam logic [OFF_W-1:0] OFF_DATA     = 6'd39;
   localparam logic [OFF_W-1:0] OFF_LAST     = 6'd43;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] FMT_SIZE = 32'd16;
   localparam logic [15:0] FMT_PCM  = 16'd1;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_NO_RIFF    = 4'd1,
      ST_NO_WAVE    = 4'd2,
      ST_NO_FMT     = 4'd3,
      ST_FMT_SIZE   = 4'd4,
      ST_NOT_PCM    = 4'd5,
      ST_CHANNELS   = 4'd6,
      ST_ALIGN      = 4'd7,
      ST_NO_DATA    = 4'd8,
      ST_ZERO_ALIGN = 4'd9
   } status_type;

   typedef enum logic {
      S_PARSE,
      S_DIVIDE
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic set_fail;
      logic start_div;
      logic div_step;
      logic set_ok;
   } cmd_type;

   typedef struct packed {
      logic fail;
      logic header_ok;
      logic div_last;
   } stat_type;

endpackage

/* hdl/wavhp_ctrl.sv */
module wavhp_ctrl
   import wavhp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PARSE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_PARSE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_PARSE: begin
            if (accept) begin
               cmd.take_byte = 1'b1;
               if (stat.fail) begin
                  cmd.set_fail = 1'b1;
                  rsp_valid_in = 1'b1;
               end else if (stat.header_ok) begin
                  cmd.start_div = 1'b1;
                  state_in      = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.set_ok   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_PARSE;
            end
         end
         default: state_in = S_PARSE;
      endcase
   end

endmodule

/* hdl/wavhp_datapath.sv */
module wavhp_datapath
   import wavhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_channels,
   output logic [31:0] rsp_sample_rate,
   output logic [31:0] rsp_bytes_per_sec,
   output logic [15:0] rsp_block_align,
   output logic [15:0] rsp_sample_bits,
   output logic [31:0] rsp_data_bytes,
   output logic [31:0] rsp_total_frames
);

   logic [OFF_W-1:0] offset_ff, offset_in;
   logic             done_ff, done_in;
   logic [31:0]      shift_ff, shift_in;
   logic [1:0]       chan_ff, chan_in;
   logic [31:0]      rate_ff, rate_in;
   logic [31:0]      brate_ff, brate_in;
   logic [15:0]      align_ff, align_in;
   logic [15:0]      bits_ff, bits_in;
   status_type       status_ff, status_in;
   status_type       fail_code;
   logic [31:0]      quot_ff, quot_in;
   logic [15:0]      rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [OFF_W-1:0] eff_off;
   logic             active;
   logic [31:0]      new_shift;
   logic [15:0]      half;
   logic [17:0]      prod;
   logic [16:0]      trial;
   logic [16:0]      diff;
   logic             ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         done_ff   <= 1'b1;
         status_ff <= ST_OK;
         cnt_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         done_ff   <= done_in;
         status_ff <= status_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      chan_ff  <= chan_in;
      rate_ff  <= rate_in;
      brate_ff <= brate_in;
      align_ff <= align_in;
      bits_ff  <= bits_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign eff_off   = req_first ? '0 : offset_ff;
   assign active    = (req_first || !done_ff) && (eff_off < OFF_W'(HDR_LEN));
   assign new_shift = {req_data_byte, shift_ff[31:8]};
   assign half      = new_shift[31:16];
   assign prod      = ({2'b00, half} & {18{chan_ff[0]}})
                    + ({1'b0, half, 1'b0} & {18{chan_ff[1]}});

   always_comb begin
      stat      = '0;
      fail_code = ST_OK;
      if (active) begin
         unique case (eff_off)
            OFF_RIFF:     if (new_shift != TAG_RIFF) fail_code = ST_NO_RIFF;
            OFF_WAVE:     if (new_shift != TAG_WAVE) fail_code = ST_NO_WAVE;
            OFF_FMT:      if (new_shift != TAG_FMT) fail_code = ST_NO_FMT;
            OFF_FMT_SIZE: if (new_shift != FMT_SIZE) fail_code = ST_FMT_SIZE;
            OFF_FORMAT:   if (half != FMT_PCM) fail_code = ST_NOT_PCM;
            OFF_CHANNELS: if (half != 16'd1 && half != 16'd2) fail_code = ST_CHANNELS;
            OFF_BITS:     if (align_ff != {1'b0, prod[17:3]}) fail_code = ST_ALIGN;
            OFF_DATA:     if (new_shift != TAG_DATA) fail_code = ST_NO_DATA;
            OFF_LAST: begin
               if (align_ff == '0) fail_code = ST_ZERO_ALIGN;
               else stat.header_ok = 1'b1;
            end
            default: fail_code = ST_OK;
         endcase
      end
      stat.fail     = (fail_code != ST_OK);
      stat.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   end

   always_comb begin
      offset_in = offset_ff;
      done_in   = done_ff;
      shift_in  = shift_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      brate_in  = brate_ff;
      align_in  = align_ff;
      bits_in   = bits_ff;
      if (cmd.take_byte) begin
         if (req_first) begin
            offset_in = '0;
            done_in   = 1'b0;
         end
         if (active) begin
            shift_in  = new_shift;
            offset_in = eff_off + 1'b1;
            done_in   = stat.fail || stat.header_ok;
            unique case (eff_off)
               OFF_CHANNELS: chan_in  = half[1:0];
               OFF_RATE:     rate_in  = new_shift;
               OFF_BYTERATE: brate_in = new_shift;
               OFF_ALIGN:    align_in = half;
               OFF_BITS:     bits_in  = half;
               default:      ;
            endcase
         end
      end
   end

   assign trial = {rem_ff, quot_ff[31]};
   assign diff  = trial - {1'b0, align_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd.start_div) begin
         quot_in = new_shift;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + 1'b1;
         if (!diff[16]) begin
            rem_in  = diff[15:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = trial[15:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
      end
   end

   always_comb begin
      status_in = status_ff;
      if (cmd.set_fail) status_in = fail_code;
      else if (cmd.set_ok) status_in = ST_OK;
   end

   assign ok                = (status_ff == ST_OK);
   assign rsp_status        = status_ff;
   assign rsp_channels      = ok ? chan_ff  : '0;
   assign rsp_sample_rate   = ok ? rate_ff  : '0;
   assign rsp_bytes_per_sec = ok ? brate_ff : '0;
   assign rsp_block_align   = ok ? align_ff : '0;
   assign rsp_sample_bits   = ok ? bits_ff  : '0;
   assign rsp_data_bytes    = ok ? shift_ff : '0;
   assign rsp_total_frames  = ok ? quot_ff  : '0;

endmodule

/* hdl/wav_header_parser_top.sv */
// Header bytes are taken one per cycle while ready; a failed check gives its result the cycle after
// the byte that completes the field.
// A good header runs a restoring divider after byte 44; the result follows it.
// No bytes are taken while the divider runs or while a result waits to be taken.
// Synchronous active-high reset; after reset bytes are ignored until one flagged first.
module wav_header_parser_top
   import wavhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_channels,
   output logic [31:0] rsp_sample_rate,
   output logic [31:0] rsp_bytes_per_sec,
   output logic [15:0] rsp_block_align,
   output logic [15:0] rsp_sample_bits,
   output logic [31:0] rsp_data_bytes,
   output logic [31:0] rsp_total_frames
);

   cmd_type  cmd;
   stat_type stat;

   wavhp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wavhp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_data_byte     (req_data_byte),
      .req_first         (req_first),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_channels      (rsp_channels),
      .rsp_sample_rate   (rsp_sample_rate),
      .rsp_bytes_per_sec (rsp_bytes_per_sec),
      .rsp_block_align   (rsp_block_align),
      .rsp_sample_bits   (rsp_sample_bits),
      .rsp_data_bytes    (rsp_data_bytes),
      .rsp_total_frames  (rsp_total_frames)
   );

`ifndef SYNTHESIS
   a_no_take_while_pending: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("byte taken while result pending");

   a_no_take_while_dividing: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_ready)
      else $error("byte taken while dividing");

   a_fail_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_channels == '0 && rsp_block_align == '0 && rsp_total_frames == '0))
      else $error("failed result carries nonzero fields");

   a_ok_has_align: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |->
         (rsp_block_align != '0 && (rsp_channels == 2'd1 || rsp_channels == 2'd2)))
      else $error("good result with bad align or channels");
`endif

endmodule
